FILE: rtl/vtp_pkg.sv
`timescale 1ns / 1ps

package vtp_pkg;

  // Character codes that steer the parser.
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_F = 8'h66;
  localparam logic [7:0] CHAR_LOW_G = 8'h67;
  localparam logic [7:0] CHAR_LOW_I = 8'h69;

  // Field count where further field events are dropped.
  localparam logic [3:0] FIELD_MAX = 4'd8;
  // Hash counter value that marks the hash as ended.
  localparam logic [3:0] HASH_END  = 4'd8;
  // Nibble written by the dirty mark.
  localparam logic [3:0] DIRTY_NIB = 4'hF;

  // Running parse state for one version string.
  typedef struct packed {
    logic [63:0] word;
    logic [7:0]  dec_acc;
    logic [3:0]  field_cnt;
    logic        dash_seen;
    logic [3:0]  hash_cnt;
    logic        dirty_done;
  } parse_state_t;

endpackage

FILE: rtl/vtp_char_step.sv
`timescale 1ns / 1ps

module vtp_char_step (
  input  vtp_pkg::parse_state_t cur_i,
  input  logic [7:0]            char_i,
  output vtp_pkg::parse_state_t nxt_o
);
  import vtp_pkg::*;

  parse_state_t st;
  logic         is_digit;
  logic         is_hex_lower;
  logic [3:0]   nib;
  logic [2:0]   nib_slot;
  logic [5:0]   field_shift;
  logic [5:0]   nib_shift;

  assign is_digit     = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign is_hex_lower = (char_i >= CHAR_LOW_A) && (char_i <= CHAR_LOW_F);

  // Nibble value of a lower-case hex digit; only used when it is one.
  assign nib = is_digit ? char_i[3:0] : 4'(char_i[3:0] + 4'd9);

  // One character applied to the state, rule by rule in model order.
  always_comb begin
    st          = cur_i;
    nib_slot    = 3'(HASH_END - cur_i.hash_cnt);
    field_shift = {~cur_i.field_cnt[2:0], 3'b000};
    nib_shift   = {1'b0, nib_slot, 2'b00};
    if (!cur_i.dirty_done) begin
      // Decimal digits build the open field until a hash starts.
      if ((st.hash_cnt == 4'd0) && is_digit) begin
        st.dec_acc = 8'({st.dec_acc, 3'b000} + {st.dec_acc, 1'b0} + {4'b0, char_i[3:0]});
      end
      // A dot or the first dash closes a field into its byte lane.
      if ((char_i == CHAR_DOT) || (!st.dash_seen && (char_i == CHAR_DASH))) begin
        if (st.field_cnt < FIELD_MAX) begin
          st.word      = st.word | ({56'b0, st.dec_acc} << field_shift);
          st.field_cnt = 4'(st.field_cnt + 4'd1);
          st.dec_acc   = 8'd0;
        end
      end
      if (char_i == CHAR_DASH) begin
        st.dash_seen = 1'b1;
      end
      // Inside the hash, lower-case hex digits fill nibbles; anything else ends it.
      if ((st.hash_cnt != 4'd0) && (st.hash_cnt < HASH_END)) begin
        if (is_digit || is_hex_lower) begin
          st.word     = st.word | ({60'b0, nib} << nib_shift);
          st.hash_cnt = 4'(st.hash_cnt + 4'd1);
        end else begin
          st.hash_cnt = HASH_END;
        end
      end
      if ((char_i == CHAR_LOW_G) && (st.hash_cnt < HASH_END)) begin
        st.hash_cnt = 4'(st.hash_cnt + 4'd1);
      end
      // An 'i' after the hash marks the string dirty and freezes it.
      if ((st.hash_cnt >= HASH_END) && (char_i == CHAR_LOW_I)) begin
        st.word[3:0]  = DIRTY_NIB;
        st.dirty_done = 1'b1;
      end
    end
  end

  assign nxt_o = st;

endmodule

FILE: rtl/version_tag_parser_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       sink       in_valid_i/in_stall_o  char_code_i[7:0], last_char_i
// out      source     out_valid_o/out_stall_i packed_version_o[63:0]
//
// One character word is accepted per cycle while the input does not stall. A
// character is held in the input register, is applied to the parse state, and a
// last character loads the result register.
// Reset clears the parse state and both valid flags.
// Input stalls only while a last character waits behind an unread result.
module version_tag_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] packed_version_o
);
  import vtp_pkg::*;

  logic         in_vld_q, in_vld_d;
  logic [7:0]   char_q;
  logic         last_q;
  logic         in_take;
  logic         advance;
  logic         out_free;
  parse_state_t state_q, state_d;
  parse_state_t state_nxt;
  logic         out_vld_q, out_vld_d;
  logic [63:0]  out_data_q;

  // The result register can take a new word when empty or being read.
  assign out_free = !out_vld_q || !out_stall_i;
  // Non-last characters always move on; a last one needs the result register.
  assign advance  = in_vld_q && (!last_q || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  vtp_char_step u_step (
    .cur_i  (state_q),
    .char_i (char_q),
    .nxt_o  (state_nxt)
  );

  // Input register control.
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // Parse state: clear after the last character of a string.
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = last_q ? '0 : state_nxt;
    end
  end

  // Result valid control.
  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && last_q) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
    if (advance && last_q) begin
      out_data_q <= state_nxt.word;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign packed_version_o = out_data_q;

endmodule

FILE: rtl/vtp_checker.sv
`timescale 1ns / 1ps

module vtp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_char_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] packed_version_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(packed_version_o))
    else $error("result word changed while stalled");

  // A new result follows an accepted last character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && last_char_i, 2))
    else $error("result word without a last character");

  // The input side only stalls behind a blocked result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is free");

endmodule

bind version_tag_parser_core vtp_checker u_vtp_checker (.*);
